/* src/asc_pkg.sv */
// Shared types, constants and field positions for the alarm snooze controller.
package asc_pkg;

    // Number of alarms and the width of an alarm number.
    localparam int NUM_ALARMS = 3;
    localparam int IDX_W      = 2;

    // Milliseconds in one minute, used for snooze and ring lengths.
    localparam logic [31:0] MS_PER_MINUTE = 32'd60000;

    // Packed settings word of one alarm.
    localparam int SET_W        = 26;
    localparam int SET_ENABLED  = 0;
    localparam int SET_DAILY    = 1;
    localparam int SET_LIMIT_LO = 2;
    localparam int SET_SNOOZE_LO = 10;
    localparam int SET_LENGTH_LO = 18;

    // Commands carried by an input word.
    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_SNOOZE  = 2'd1,
        CMD_BACK    = 2'd2,
        CMD_CHANGED = 2'd3
    } cmd_t;

    // Event codes reported with each result word.
    typedef enum logic [3:0] {
        EV_NONE       = 4'd0,
        EV_STARTED    = 4'd1,
        EV_RESTARTED  = 4'd2,
        EV_SNOOZED    = 4'd3,
        EV_REFUSED    = 4'd4,
        EV_COUNTDOWN  = 4'd5,
        EV_DISMISSED  = 4'd6,
        EV_EXPIRED    = 4'd7,
        EV_UNCONSUMED = 4'd8
    } event_t;

    typedef logic [NUM_ALARMS-1:0][SET_W-1:0] settings_t;

    // One input word.
    typedef struct packed {
        cmd_t                  cmd;
        logic [31:0]           now_ms;
        logic [NUM_ALARMS-1:0] due_mask;
        logic [IDX_W-1:0]      alarm_index;
    } item_t;

    // One result word.
    typedef struct packed {
        logic                  ringing;
        logic [IDX_W-1:0]      ring_index;
        logic [7:0]            snoozes_used;
        event_t                event_res;
        logic [NUM_ALARMS-1:0] disarmed_mask;
    } result_t;

    // Controller state carried from one word to the next.
    typedef struct packed {
        logic                         is_ringing;
        logic [IDX_W-1:0]             ringing_alarm;
        logic [31:0]                  ring_start_ms;
        logic [NUM_ALARMS-1:0][7:0]   snooze_count;
        logic [NUM_ALARMS-1:0][31:0]  snooze_due_ms;
        logic [NUM_ALARMS-1:0]        snooze_active;
        logic [NUM_ALARMS-1:0]        pending_set;
        logic [NUM_ALARMS-1:0]        oneshot_off;
    } state_t;

endpackage

/* src/asc_req_if.sv */
// Input channel carrying one command word per handshake.
interface asc_req_if import asc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [1:0]            cmd;
    logic [31:0]           now_ms;
    logic [NUM_ALARMS-1:0] due_mask;
    logic [IDX_W-1:0]      alarm_index;

    modport source (output valid, cmd, now_ms, due_mask, alarm_index, input ready);
    modport sink   (input valid, cmd, now_ms, due_mask, alarm_index, output ready);
endinterface

/* src/asc_rsp_if.sv */
// Output channel carrying one result word per handshake.
interface asc_rsp_if import asc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  ringing;
    logic [IDX_W-1:0]      ring_index;
    logic [7:0]            snoozes_used;
    logic [3:0]            event_res;
    logic [NUM_ALARMS-1:0] disarmed_mask;

    modport source (output valid, ringing, ring_index, snoozes_used, event_res,
                    disarmed_mask, input ready);
    modport sink   (input valid, ringing, ring_index, snoozes_used, event_res,
                    disarmed_mask, output ready);
endinterface

/* src/asc_cfg_if.sv */
// Configuration write channel carrying a register index and write data.
interface asc_cfg_if import asc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [SET_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/asc_step.sv */
// Next-state and result logic for one command word.
module asc_step import asc_pkg::*;
(
    input  item_t     item,
    input  state_t    state,
    input  settings_t settings,
    output state_t    state_next,
    output result_t   result
);

    logic        found;
    logic        enabled;
    logic [31:0] elapsed;
    logic [31:0] len_ms;
    logic [31:0] snooze_ms;
    logic [7:0]  len_min;
    logic [IDX_W-1:0] r;
    logic [31:0] due_diff [NUM_ALARMS];
    event_t      ev;
    state_t      st;

    // Ring length and snooze length of the ringing alarm, in milliseconds.
    assign r         = state.ringing_alarm;
    assign len_min   = settings[r][SET_LENGTH_LO +: 8];
    assign len_ms    = 32'(32'(len_min) * MS_PER_MINUTE);
    assign snooze_ms = 32'(32'(settings[r][SET_SNOOZE_LO +: 8]) * MS_PER_MINUTE);
    assign elapsed   = item.now_ms - state.ring_start_ms;

    // Time past each alarm's snooze due time, wrapping at 32 bits.
    always_comb
    begin
        for (int i = 0; i < NUM_ALARMS; i++)
        begin
            due_diff[i] = item.now_ms - state.snooze_due_ms[i];
        end
    end

    // Command decode and state update.
    always_comb
    begin
        st      = state;
        ev      = EV_NONE;
        found   = 1'b0;
        enabled = 1'b0;
        case (item.cmd)
            CMD_TICK:
            begin
                st.pending_set = state.pending_set | item.due_mask;
                if (!state.is_ringing)
                begin
                    // Lowest-numbered enabled alarm that is due wins.
                    for (int i = 0; i < NUM_ALARMS; i++)
                    begin
                        if (!found)
                        begin
                            enabled = settings[i][SET_ENABLED] && !state.oneshot_off[i];
                            if (!enabled)
                            begin
                                st.snooze_active[i] = 1'b0;
                                st.pending_set[i]   = 1'b0;
                            end
                            else if (state.snooze_active[i] && !due_diff[i][31])
                            begin
                                st.snooze_active[i] = 1'b0;
                                st.is_ringing       = 1'b1;
                                st.ringing_alarm    = IDX_W'(i);
                                st.ring_start_ms    = item.now_ms;
                                ev                  = EV_RESTARTED;
                                found               = 1'b1;
                            end
                            else if (st.pending_set[i])
                            begin
                                st.pending_set[i]   = 1'b0;
                                st.snooze_count[i]  = 8'd0;
                                st.snooze_active[i] = 1'b0;
                                st.is_ringing       = 1'b1;
                                st.ringing_alarm    = IDX_W'(i);
                                st.ring_start_ms    = item.now_ms;
                                ev                  = EV_STARTED;
                                found               = 1'b1;
                            end
                        end
                    end
                end
                else if (len_min != 8'd0 && elapsed >= len_ms)
                begin
                    // Ring length has run out: end it like a dismissal.
                    st.snooze_active[r] = 1'b0;
                    if (!settings[r][SET_DAILY] && settings[r][SET_ENABLED] &&
                        !state.oneshot_off[r])
                    begin
                        st.oneshot_off[r] = 1'b1;
                    end
                    st.is_ringing = 1'b0;
                    ev            = EV_EXPIRED;
                end
            end
            CMD_SNOOZE:
            begin
                if (state.is_ringing)
                begin
                    if (state.snooze_count[r] >= settings[r][SET_LIMIT_LO +: 8])
                    begin
                        ev = EV_REFUSED;
                    end
                    else
                    begin
                        st.snooze_count[r]  = state.snooze_count[r] + 8'd1;
                        st.snooze_due_ms[r] = item.now_ms + snooze_ms;
                        st.snooze_active[r] = 1'b1;
                        st.is_ringing       = 1'b0;
                        ev                  = EV_SNOOZED;
                    end
                end
                else
                begin
                    ev = EV_COUNTDOWN;
                end
            end
            CMD_BACK:
            begin
                if (state.is_ringing)
                begin
                    st.snooze_active[r] = 1'b0;
                    if (!settings[r][SET_DAILY] && settings[r][SET_ENABLED] &&
                        !state.oneshot_off[r])
                    begin
                        st.oneshot_off[r] = 1'b1;
                    end
                    st.is_ringing = 1'b0;
                    ev            = EV_DISMISSED;
                end
                else
                begin
                    ev = EV_UNCONSUMED;
                end
            end
            CMD_CHANGED:
            begin
                // Edited alarm loses its snooze, pending bit and disarm bit.
                if (item.alarm_index < IDX_W'(NUM_ALARMS))
                begin
                    st.snooze_active[item.alarm_index] = 1'b0;
                    st.pending_set[item.alarm_index]   = 1'b0;
                    st.oneshot_off[item.alarm_index]   = 1'b0;
                end
            end
            default:
            begin
                st = state;
            end
        endcase
    end

    assign state_next           = st;
    assign result.ringing       = st.is_ringing;
    assign result.ring_index    = st.ringing_alarm;
    assign result.snoozes_used  = st.snooze_count[st.ringing_alarm];
    assign result.event_res     = ev;
    assign result.disarmed_mask = st.oneshot_off;

endmodule

/* src/alarm_snooze_controller.sv */
// Top level of the alarm snooze controller: registers, handshakes and settings.
//
// Each command word yields exactly one result word. A word accepted on req is
// held in an input register, evaluated combinationally against the controller
// state, and its result is loaded into an output register once that register
// is free or being emptied. A new word can be taken every cycle unless rsp
// stalls, and req stays ready while a finished result waits on rsp as long as
// the input register can move forward. Settings are written on cfg at any time,
// one register per word, index 0 to 2 for alarms 0 to 2; other indexes are
// dropped. They should only change while no command word is in flight.
module alarm_snooze_controller import asc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    asc_req_if.sink    req,
    asc_rsp_if.source  rsp,
    asc_cfg_if.sink    cfg
);

    logic      in_valid_reg;
    item_t     in_reg;
    logic      out_valid_reg;
    result_t   out_reg;
    state_t    state_reg;
    state_t    state_next;
    result_t   result_next;
    settings_t settings_reg;
    logic      advance;

    // The held word moves on when the output register is free or being emptied.
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_reg.cmd         <= cmd_t'(req.cmd);
            in_reg.now_ms      <= req.now_ms;
            in_reg.due_mask    <= req.due_mask;
            in_reg.alarm_index <= req.alarm_index;
        end
    end

    // Settings registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settings_reg <= '0;
        end
        else if (cfg.valid && cfg.index < IDX_W'(NUM_ALARMS))
        begin
            settings_reg[cfg.index] <= cfg.data;
        end
    end

    asc_step u_step
    (
        .item       (in_reg),
        .state      (state_reg),
        .settings   (settings_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Controller state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.ringing       = out_reg.ringing;
    assign rsp.ring_index    = out_reg.ring_index;
    assign rsp.snoozes_used  = out_reg.snoozes_used;
    assign rsp.event_res     = out_reg.event_res;
    assign rsp.disarmed_mask = out_reg.disarmed_mask;

endmodule
